// File: src/brq_pkg.sv
// shared types and constants for the bounded ring queue with overwrite
// no dependencies; imported by the cell and the top level
package brq_pkg;

	localparam int DEF_CAPACITY   = 16;
	localparam int DEF_DATA_WIDTH = 32;

	// field widths of the stream items
	localparam int CMD_W       = 2;
	localparam int VALUE_W     = 32;
	localparam int OCC_W       = 5;
	localparam int IN_TDATA_W  = 32;
	localparam int IN_TUSER_W  = 8;
	localparam int OUT_TDATA_W = 48;

	// result bit positions in m_tdata
	localparam int RES_ACC_B   = 0;
	localparam int RES_VAL_LO  = 1;
	localparam int RES_DROP_B  = RES_VAL_LO + VALUE_W;
	localparam int RES_OCC_LO  = RES_DROP_B + 1;
	localparam int RES_EMPTY_B = RES_OCC_LO + OCC_W;
	localparam int RES_FULL_B  = RES_EMPTY_B + 1;
	localparam int RES_USED_W  = RES_FULL_B + 1;

	// command codes
	localparam logic [CMD_W-1:0] CMD_ENQ     = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ENQ_OVR = 2'd1;
	localparam logic [CMD_W-1:0] CMD_DEQ     = 2'd2;

	// per-step control broadcast to every cell
	typedef struct packed {
		logic shift;
		logic load;
	} brq_cell_ctl_t;

endpackage

// File: src/brq_cell.sv
// one storage cell of the queue chain
// depends on brq_pkg for the cell control struct
module brq_cell
	import brq_pkg::*;
#(
	parameter int IDX     = 0,
	parameter int COUNT_W = 5,
	parameter int STORE_W = 32
) (
	input  logic               clk,
	input  brq_cell_ctl_t      ctl,
	input  logic [COUNT_W-1:0] count,
	input  logic [STORE_W-1:0] new_value,
	input  logic [STORE_W-1:0] next_value,
	output logic [STORE_W-1:0] value
);

	logic [STORE_W-1:0] value_q;

	// shift toward the head, or take the new value when this is the tail slot
	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			value_q <= next_value;
		end else if (ctl.load && (count == COUNT_W'(IDX))) begin
			value_q <= new_value;
		end
	end

	assign value = value_q;

endmodule

// File: src/bounded_ring_queue_overwrite_unit.sv
// top level of the bounded queue with overwrite: control, count and result register
// depends on brq_pkg and brq_cell
//
// A first-in first-out queue of CAPACITY entries built as a chain of cells, cell 0 always
// holding the oldest entry. Commands arrive on the s_ stream (command in s_tuser, value in
// s_tdata) and every accepted transaction gives exactly one result transaction on the m_
// stream. Enqueue writes the cell at the current occupancy; dequeue, and an overwrite
// enqueue into a full queue, shift the whole chain one cell toward the head, the
// overwrite loading the new value into the last cell. One command is taken per clock:
// the chain updates in the cycle of acceptance and the result sits in a single output
// register, so s_tready stays high whenever that register is empty or is being drained in
// the same cycle. Throughput is one transaction per cycle while the m_ side keeps up; a
// stalled m_ side holds the queue after one result. No clearing pass is needed after reset:
// only the count and valid flag are reset; cells beyond the count are never read. Only the
// low DATA_WIDTH bits of a value are stored (at most 32); results zero extend them.
module bounded_ring_queue_overwrite_unit
	import brq_pkg::*;
#(
	parameter int CAPACITY   = DEF_CAPACITY,
	parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,  // [31:0] item_value
	input  logic [IN_TUSER_W-1:0]  s_tuser,  // [1:0] command, [7:2] zero
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata   // [0] accepted, [32:1] out_value,
	                                         // [33] dropped_oldest, [38:34] occupancy,
	                                         // [39] is_empty, [40] is_full, [47:41] zero
);

	// stored width: bits above the value field are always zero
	localparam int STORE_W = (DATA_WIDTH < VALUE_W) ? DATA_WIDTH : VALUE_W;
	localparam int COUNT_W = $clog2(CAPACITY + 1);

	logic                   in_fire;
	logic [CMD_W-1:0]       cmd;
	logic [STORE_W-1:0]     new_value;
	logic                   full;
	logic                   empty;

	logic [COUNT_W-1:0]     count_q;
	logic [COUNT_W-1:0]     count_nxt;

	logic                   m_tvalid_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;

	// step decision
	logic                   acc;
	logic                   drop;
	logic                   inc;
	logic                   dec;
	logic                   deq_taken;
	brq_cell_ctl_t          ctl;

	// cell chain taps
	logic [STORE_W-1:0]     cell_val [CAPACITY];

	// result assembly
	logic [COUNT_W+OCC_W-1:0] occ_ext;
	logic [VALUE_W-1:0]       res_value;
	logic [OUT_TDATA_W-1:0]   res_word;

	assign cmd       = s_tuser[CMD_W-1:0];
	assign new_value = s_tdata[STORE_W-1:0];
	assign s_tready  = !m_tvalid_q || m_tready;
	assign in_fire   = s_tvalid && s_tready;

	assign full  = (count_q == COUNT_W'(CAPACITY));
	assign empty = (count_q == '0);

	// decode the command against the current occupancy
	always_comb begin
		acc       = 1'b0;
		drop      = 1'b0;
		inc       = 1'b0;
		dec       = 1'b0;
		deq_taken = 1'b0;
		ctl       = '0;
		unique case (cmd)
			CMD_ENQ: begin
				acc      = !full;
				inc      = !full;
				ctl.load = !full;
			end
			CMD_ENQ_OVR: begin
				acc = 1'b1;
				if (full) begin
					// drop the oldest, new value enters the last cell
					drop      = 1'b1;
					ctl.shift = 1'b1;
				end else begin
					inc      = 1'b1;
					ctl.load = 1'b1;
				end
			end
			CMD_DEQ: begin
				acc       = !empty;
				dec       = !empty;
				deq_taken = !empty;
				ctl.shift = !empty;
			end
			default: begin
				// unused code: no effect, refused
			end
		endcase
		// nothing moves without a transaction
		if (!in_fire) begin
			ctl = '0;
		end
	end

	always_comb begin
		count_nxt = count_q;
		if (in_fire && inc) begin
			count_nxt = count_q + COUNT_W'(1);
		end else if (in_fire && dec) begin
			count_nxt = count_q - COUNT_W'(1);
		end
	end

	// chain of cells, the last one fed by the incoming value
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [STORE_W-1:0] nb_value;
		if (i == CAPACITY - 1) begin : g_tail
			assign nb_value = new_value;
		end else begin : g_mid
			assign nb_value = cell_val[i+1];
		end
		brq_cell #(
			.IDX     (i),
			.COUNT_W (COUNT_W),
			.STORE_W (STORE_W)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.count      (count_q),
			.new_value  (new_value),
			.next_value (nb_value),
			.value      (cell_val[i])
		);
	end

	// occupancy field keeps the low bits of the count
	assign occ_ext   = {{OCC_W{1'b0}}, count_nxt};
	assign res_value = deq_taken ? VALUE_W'(cell_val[0]) : '0;

	always_comb begin
		res_word              = '0;
		res_word[RES_ACC_B]   = acc;
		res_word[RES_DROP_B]  = drop;
		res_word[RES_EMPTY_B] = (count_nxt == '0);
		res_word[RES_FULL_B]  = (count_nxt == COUNT_W'(CAPACITY));
		res_word[RES_VAL_LO +: VALUE_W] = res_value;
		res_word[RES_OCC_LO +: OCC_W]   = occ_ext[OCC_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			count_q <= count_nxt;
			if (in_fire) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (in_fire) begin
			m_tdata_q <= res_word;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// occupancy never passes the capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_W'(CAPACITY))
		else $error("queue count above capacity");

	// every accepted command leaves a result waiting
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> m_tvalid_q)
		else $error("result missing after accepted command");

	// overwrite into a full queue keeps it full and flags the drop
	a_overwrite_full: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && cmd == CMD_ENQ_OVR && full) |=>
		(count_q == COUNT_W'(CAPACITY) && m_tdata_q[RES_DROP_B] && m_tdata_q[RES_FULL_B]))
		else $error("overwrite on full queue misbehaved");

	// a dequeue from a non-empty queue lowers the count by one
	a_deq_count: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && cmd == CMD_DEQ && !empty) |=>
		(count_q == $past(count_q) - COUNT_W'(1) && m_tdata_q[RES_ACC_B]))
		else $error("dequeue did not lower the count");

endmodule
